/* rtl/core/gbn_pkg.sv */
`default_nettype none

package gbn_pkg;

  localparam int unsigned WindowDepth = 4;
  localparam int unsigned SlotBits    = 2;
  localparam int unsigned SeqBits     = 3;
  localparam int unsigned CntBits     = 3;
  localparam int unsigned PayloadBits = 64;
  localparam int unsigned TimerBits   = 16;
  localparam int unsigned WinCfgBits  = 3;
  localparam int unsigned CfgIdxBits  = 1;

  localparam logic [CntBits-1:0]    WindowDepthCnt = CntBits'(WindowDepth);
  localparam logic [WinCfgBits-1:0] WindowReset    = WinCfgBits'(4);
  localparam logic [TimerBits-1:0]  TimeoutReset   = TimerBits'(20);

  localparam logic [CfgIdxBits-1:0] CFG_WINDOW_SIZE   = 1'b0;
  localparam logic [CfgIdxBits-1:0] CFG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACK_NONE     = 2'd0,
    ACK_ACCEPTED = 2'd1,
    ACK_CSUM_ERR = 2'd2,
    ACK_DUP      = 2'd3
  } ack_status_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic retx_emit;
  } gbn_cmd_t;

  typedef struct packed {
    logic out_free;
    logic retx_needed;
    logic retx_last;
  } gbn_status_t;

endpackage

`default_nettype wire

/* rtl/core/gbn_ctrl.sv */
`default_nettype none

module gbn_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  gbn_pkg::gbn_status_t status_i,
  output gbn_pkg::gbn_cmd_t    cmd_o
);
  import gbn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RETX = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.retx_needed) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_RETX;
        end else if (status_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_RETX: begin
        if (status_i.out_free) begin
          cmd_o.retx_emit = 1'b1;
          if (status_i.retx_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/gbn_dp.sv */
`default_nettype none

module gbn_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gbn_pkg::gbn_cmd_t                    cmd_i,
  output gbn_pkg::gbn_status_t                 status_o,
  input  logic                                 cfg_we_i,
  input  logic [gbn_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [gbn_pkg::TimerBits-1:0]        cfg_data_i,
  input  logic [1:0]                           op_i,
  input  logic [gbn_pkg::PayloadBits-1:0]      payload_i,
  input  logic [gbn_pkg::SeqBits-1:0]          ack_num_i,
  input  logic                                 ack_checksum_ok_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 accepted_o,
  output logic                                 pkt_valid_o,
  output logic [gbn_pkg::SeqBits-1:0]          pkt_seq_o,
  output logic [gbn_pkg::PayloadBits-1:0]      pkt_payload_o,
  output logic                                 is_retransmit_o,
  output logic [1:0]                           ack_status_o,
  output logic [gbn_pkg::CntBits-1:0]          outstanding_o,
  output logic                                 last_o
);
  import gbn_pkg::*;

  logic [PayloadBits-1:0] store_q [WindowDepth];

  op_e                    op_q;
  logic [PayloadBits-1:0] pay_q;
  logic [SeqBits-1:0]     ack_num_q;
  logic                   ack_ok_q;

  logic [SlotBits-1:0]   head_q, head_d;
  logic [SeqBits-1:0]    base_q, base_d;
  logic [SeqBits-1:0]    next_q, next_d;
  logic [CntBits-1:0]    count_q, count_d;
  logic                  run_q, run_d;
  logic [TimerBits-1:0]  left_q, left_d;
  logic [SlotBits-1:0]   idx_q, idx_d;
  logic [WinCfgBits-1:0] win_q;
  logic [TimerBits-1:0]  tmo_q;
  logic                  out_valid_q, out_valid_d;

  logic                   out_load;
  logic                   res_accepted;
  logic                   res_pkt_valid;
  logic [SeqBits-1:0]     res_seq;
  logic [PayloadBits-1:0] res_payload;
  logic                   res_retx;
  ack_status_e            res_status;
  logic                   res_last;

  logic [CntBits-1:0]  eff_win;
  logic                send_ok;
  logic [SlotBits-1:0] wr_slot;
  logic [SlotBits-1:0] rd_slot;
  logic                store_we;
  logic [SeqBits-1:0]  ack_off;
  logic [SeqBits-1:0]  ack_n;
  logic                ack_hit;
  logic                expire;
  logic                out_free;
  logic                retx_last;

  assign eff_win   = (win_q > WindowDepthCnt) ? WindowDepthCnt : win_q;
  assign send_ok   = (count_q < eff_win);
  assign wr_slot   = head_q + count_q[SlotBits-1:0];
  assign rd_slot   = head_q + idx_q;
  assign ack_off   = ack_num_q - base_q;
  assign ack_n     = ack_off + SeqBits'(1);
  assign ack_hit   = ack_ok_q && (ack_off < count_q);
  assign expire    = run_q && (left_q <= TimerBits'(1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign retx_last = ((CntBits'(idx_q) + CntBits'(1)) == count_q);

  assign status_o.out_free    = out_free;
  assign status_o.retx_needed = (op_q == OP_TICK) && expire && (count_q != '0);
  assign status_o.retx_last   = retx_last;

  always_comb begin
    head_d        = head_q;
    base_d        = base_q;
    next_d        = next_q;
    count_d       = count_q;
    run_d         = run_q;
    left_d        = left_q;
    idx_d         = idx_q;
    store_we      = 1'b0;
    out_load      = 1'b0;
    res_accepted  = 1'b0;
    res_pkt_valid = 1'b0;
    res_seq       = '0;
    res_payload   = '0;
    res_retx      = 1'b0;
    res_status    = ACK_NONE;
    res_last      = 1'b1;

    if (cmd_i.exec) begin
      unique case (op_q)
        OP_SEND: begin
          out_load = 1'b1;
          if (send_ok) begin
            store_we = 1'b1;
            if (count_q == '0) begin
              run_d  = 1'b1;
              left_d = tmo_q;
            end
            count_d       = count_q + CntBits'(1);
            next_d        = next_q + SeqBits'(1);
            res_accepted  = 1'b1;
            res_pkt_valid = 1'b1;
            res_seq       = next_q;
            res_payload   = pay_q;
          end
        end
        OP_ACK: begin
          out_load = 1'b1;
          if (ack_hit) begin
            count_d    = count_q - ack_n;
            head_d     = head_q + ack_n[SlotBits-1:0];
            base_d     = base_q + ack_n;
            res_status = ACK_ACCEPTED;
            if (count_q != ack_n) begin
              run_d  = 1'b1;
              left_d = tmo_q;
            end else begin
              run_d  = 1'b0;
              left_d = '0;
            end
          end else if (!ack_ok_q) begin
            res_status = ACK_CSUM_ERR;
          end else begin
            res_status = ACK_DUP;
          end
        end
        OP_TICK: begin
          if (run_q) begin
            if (!expire) begin
              left_d = left_q - TimerBits'(1);
            end else begin
              run_d  = 1'b1;
              left_d = tmo_q;
            end
          end
          idx_d    = '0;
          out_load = !status_o.retx_needed;
        end
        OP_NONE: begin
          out_load = 1'b1;
        end
        default: begin
          out_load = 1'b1;
        end
      endcase
    end else if (cmd_i.retx_emit) begin
      out_load      = 1'b1;
      res_pkt_valid = 1'b1;
      res_seq       = base_q + SeqBits'(idx_q);
      res_payload   = store_q[rd_slot];
      res_retx      = 1'b1;
      res_last      = retx_last;
      idx_d         = idx_q + SlotBits'(1);
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      base_q      <= '0;
      next_q      <= '0;
      count_q     <= '0;
      run_q       <= 1'b0;
      left_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      win_q       <= WindowReset;
      tmo_q       <= TimeoutReset;
    end else begin
      head_q      <= head_d;
      base_q      <= base_d;
      next_q      <= next_d;
      count_q     <= count_d;
      run_q       <= run_d;
      left_q      <= left_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WINDOW_SIZE:   win_q <= cfg_data_i[WinCfgBits-1:0];
          CFG_TIMEOUT_TICKS: tmo_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_e'(op_i);
      pay_q     <= payload_i;
      ack_num_q <= ack_num_i;
      ack_ok_q  <= ack_checksum_ok_i;
    end
    if (store_we) begin
      store_q[wr_slot] <= pay_q;
    end
    if (out_load) begin
      accepted_o      <= res_accepted;
      pkt_valid_o     <= res_pkt_valid;
      pkt_seq_o       <= res_seq;
      pkt_payload_o   <= res_payload;
      is_retransmit_o <= res_retx;
      ack_status_o    <= res_status;
      outstanding_o   <= count_d;
      last_o          <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/go_back_n_sender.sv */
// A result word is loaded into the output register when its captured word executes.
// Send, ack and tick words are captured in the idle state and run in the exec state;
// a timeout that resends k stored packets then reads them one by one from the store.
// A stalled output holds the next result, so the store read port and the output
// register set the pace. Reset clears all window and timer state and loads the
// window size 4 and timeout 20; the packet store is not cleared.
`default_nettype none

module go_back_n_sender (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           op_i,
  input  logic [gbn_pkg::PayloadBits-1:0]      payload_i,
  input  logic [gbn_pkg::SeqBits-1:0]          ack_num_i,
  input  logic                                 ack_checksum_ok_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 accepted_o,
  output logic                                 pkt_valid_o,
  output logic [gbn_pkg::SeqBits-1:0]          pkt_seq_o,
  output logic [gbn_pkg::PayloadBits-1:0]      pkt_payload_o,
  output logic                                 is_retransmit_o,
  output logic [1:0]                           ack_status_o,
  output logic [gbn_pkg::CntBits-1:0]          outstanding_o,
  output logic                                 last_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gbn_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [gbn_pkg::TimerBits-1:0]        cfg_data_i
);
  import gbn_pkg::*;

  gbn_cmd_t    cmd;
  gbn_status_t status;

  assign cfg_ready_o = 1'b1;

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbn_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .payload_i         (payload_i),
    .ack_num_i         (ack_num_i),
    .ack_checksum_ok_i (ack_checksum_ok_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .accepted_o        (accepted_o),
    .pkt_valid_o       (pkt_valid_o),
    .pkt_seq_o         (pkt_seq_o),
    .pkt_payload_o     (pkt_payload_o),
    .is_retransmit_o   (is_retransmit_o),
    .ack_status_o      (ack_status_o),
    .outstanding_o     (outstanding_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire
